>>> design/ibmt_pkg.sv
// Package for the inode block map translator: payload structs, command and
// status codes, controller states and the controller/datapath link structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ibmt_pkg;

	// Input item, fields in channel order
	typedef struct packed {
		logic [1:0]  cmd;
		logic [3:0]  map_slot;
		logic [5:0]  store_block;
		logic [8:0]  store_entry;
		logic [31:0] value;
		logic [31:0] logical_block;
	} req_t;

	// Result item
	typedef struct packed {
		logic [3:0]  status;
		logic [31:0] mapped_value;
	} rsp_t;

	// Item commands
	localparam logic [1:0] CMD_MAP_LOAD   = 2'd0;
	localparam logic [1:0] CMD_STORE_LOAD = 2'd1;
	localparam logic [1:0] CMD_TRANSLATE  = 2'd2;

	// Result status codes
	localparam logic [3:0] STAT_OK           = 4'd0;
	localparam logic [3:0] STAT_DIRECT_RANGE = 4'd1;
	localparam logic [3:0] STAT_IND_ZERO     = 4'd2;
	localparam logic [3:0] STAT_IND_RANGE    = 4'd3;
	localparam logic [3:0] STAT_IND_ENTRY    = 4'd4;
	localparam logic [3:0] STAT_DBL_ZERO     = 4'd5;
	localparam logic [3:0] STAT_DBL_RANGE    = 4'd6;
	localparam logic [3:0] STAT_L1_ZERO      = 4'd7;
	localparam logic [3:0] STAT_L1_RANGE     = 4'd8;
	localparam logic [3:0] STAT_DBL_ENTRY    = 4'd9;
	localparam logic [3:0] STAT_TRIPLE       = 4'd10;
	localparam logic [3:0] STAT_BEYOND       = 4'd11;

	// Configuration register indexes
	localparam logic [2:0] CFG_DIRECT_COUNT   = 3'd0;
	localparam logic [2:0] CFG_INDIRECT_SLOT  = 3'd1;
	localparam logic [2:0] CFG_DOUBLE_SLOT    = 3'd2;
	localparam logic [2:0] CFG_TRIPLE_PRESENT = 3'd3;
	localparam logic [2:0] CFG_ZONE_COUNT     = 3'd4;
	localparam logic [2:0] CFG_ENTRIES_LOG2   = 3'd5;
	localparam logic [2:0] CFG_SHORT_ENTRIES  = 3'd6;

	// Configuration reset values
	localparam logic [3:0] RST_DIRECT_COUNT   = 4'd12;
	localparam logic [3:0] RST_INDIRECT_SLOT  = 4'd12;
	localparam logic [3:0] RST_DOUBLE_SLOT    = 4'd13;
	localparam logic       RST_TRIPLE_PRESENT = 1'b1;
	localparam logic [6:0] RST_ZONE_COUNT     = 7'd64;
	localparam logic [3:0] RST_ENTRIES_LOG2   = 4'd8;
	localparam logic       RST_SHORT_ENTRIES  = 1'b0;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POINTER,
		ST_LEVEL1,
		ST_LEVEL2,
		ST_EMIT
	} fsm_state_t;

	// Which part of the map a logical block falls in
	typedef enum logic [1:0] {
		REG_DIRECT,
		REG_IND,
		REG_DBL,
		REG_BEYOND
	} region_t;

	// Controller to datapath
	typedef struct packed {
		logic accept;
		logic decode;
		logic pointer;
		logic level1;
		logic level2;
		logic emit;
	} ctl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic item_translate;
		logic ptr_read;
		logic l1_read;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

>>> design/ibmt_ctrl.sv
// Controller state machine of the inode block map translator.
// Depends on ibmt_pkg for states and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module ibmt_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_ready,
	input  ibmt_pkg::dp_status_t status,
	output ibmt_pkg::ctl_cmd_t   cmd
);
	import ibmt_pkg::*;

	fsm_state_t state_q;
	fsm_state_t state_d;

	// Hold the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid && status.item_translate) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				state_d = ST_POINTER;
			end
			ST_POINTER: begin
				state_d = status.ptr_read ? ST_LEVEL1 : ST_EMIT;
			end
			ST_LEVEL1: begin
				state_d = status.l1_read ? ST_LEVEL2 : ST_EMIT;
			end
			ST_LEVEL2: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Commands to the datapath
	always_comb begin
		req_ready   = (state_q == ST_IDLE);
		cmd.accept  = (state_q == ST_IDLE) && req_valid;
		cmd.decode  = (state_q == ST_DECODE);
		cmd.pointer = (state_q == ST_POINTER);
		cmd.level1  = (state_q == ST_LEVEL1);
		cmd.level2  = (state_q == ST_LEVEL2);
		cmd.emit    = (state_q == ST_EMIT);
	end

`ifndef ASSERT_OFF
	a_translate_starts: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && status.item_translate |=> state_q == ST_DECODE)
		else $error("accepted translate did not start decode");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) && !status.out_free |=> state_q == ST_EMIT)
		else $error("emit left while output register was busy");

	a_level2_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LEVEL2 |-> $past(state_q) == ST_LEVEL1)
		else $error("second store read without first");
`endif

endmodule

`default_nettype wire

>>> design/ibmt_datapath.sv
// Datapath of the inode block map translator: configuration registers,
// inode map, block store memory, decode, pointer checks and result registers.
// Depends on ibmt_pkg for payload structs, codes and link structs.
`timescale 1ns / 1ps
`default_nettype none

module ibmt_datapath #(
	parameter int MAP_SLOTS    = 15,
	parameter int STORE_BLOCKS = 64,
	parameter int MAX_ENTRIES  = 512
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ibmt_pkg::req_t       req,
	input  ibmt_pkg::ctl_cmd_t   cmd,
	output ibmt_pkg::dp_status_t status,
	input  logic                 cfg_valid,
	input  logic [2:0]           cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	output ibmt_pkg::rsp_t       rsp
);
	import ibmt_pkg::*;

	localparam int DEPTH   = STORE_BLOCKS * MAX_ENTRIES;
	localparam int ADDR_W  = $clog2(DEPTH);
	localparam int IDX_W   = $clog2(MAX_ENTRIES);
	localparam int BLK_W   = $clog2(STORE_BLOCKS);
	localparam int SLOT_IW = $clog2(MAP_SLOTS);
	localparam int LMAX    = $clog2(MAX_ENTRIES + 1) - 1;

	// Configuration registers
	logic [3:0] direct_count_q;
	logic [3:0] indirect_slot_q;
	logic [3:0] double_slot_q;
	logic       triple_present_q;
	logic [6:0] zone_count_q;
	logic [3:0] entries_log2_q;
	logic       short_entries_q;

	// Storage
	logic [31:0] map_q [MAP_SLOTS];
	logic [31:0] store_mem [DEPTH];

	// Item registers
	logic [31:0]      blk_q;
	region_t          region_q;
	logic [3:0]       slot_q;
	logic [IDX_W-1:0] ent_q;
	logic [IDX_W-1:0] lo_q;
	logic [31:0]      res_a_q;
	logic [31:0]      res_b_q;
	logic [31:0]      rd_data_q;
	logic             rd_zero_q;
	rsp_t             res_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	// Combinational
	logic [3:0]        eff_l;
	logic [10:0]       z_val;
	logic [20:0]       zz_val;
	logic [31:0]       nd;
	logic [31:0]       zmask;
	logic [31:0]       lim_ind;
	logic [31:0]       base2;
	logic [31:0]       lim_dbl;
	logic [31:0]       b1;
	logic [31:0]       b2;
	logic              ind_en;
	logic              dbl_en;
	region_t           region_d;
	logic [3:0]        slot_d;
	logic [IDX_W-1:0]  ent_d;
	logic [31:0]       res_a_d;
	logic [31:0]       zc32;
	logic [31:0]       ptr;
	logic              ptr_zero;
	logic              ptr_ok;
	logic              ptr_read;
	logic [31:0]       data;
	logic              l1_read;
	logic [31:0]       load_val;
	logic              map_wr;
	logic              store_wr;
	logic [31:0]       wr_lin;
	logic [31:0]       rd_blk;
	logic [IDX_W-1:0]  rd_ent;
	logic              rd_req;
	logic              rd_in_range;
	logic              rd_en;
	logic [31:0]       rd_lin;
	logic              res_load;
	rsp_t              res_d;
	logic              out_free;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direct_count_q   <= RST_DIRECT_COUNT;
			indirect_slot_q  <= RST_INDIRECT_SLOT;
			double_slot_q    <= RST_DOUBLE_SLOT;
			triple_present_q <= RST_TRIPLE_PRESENT;
			zone_count_q     <= RST_ZONE_COUNT;
			entries_log2_q   <= RST_ENTRIES_LOG2;
			short_entries_q  <= RST_SHORT_ENTRIES;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DIRECT_COUNT:   direct_count_q   <= cfg_data[3:0];
				CFG_INDIRECT_SLOT:  indirect_slot_q  <= cfg_data[3:0];
				CFG_DOUBLE_SLOT:    double_slot_q    <= cfg_data[3:0];
				CFG_TRIPLE_PRESENT: triple_present_q <= cfg_data[0];
				CFG_ZONE_COUNT:     zone_count_q     <= cfg_data[6:0];
				CFG_ENTRIES_LOG2:   entries_log2_q   <= cfg_data[3:0];
				CFG_SHORT_ENTRIES:  short_entries_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Clamp entries per block to at least two and at most what a block holds
	always_comb begin
		eff_l = (entries_log2_q == 4'd0) ? 4'd1 : entries_log2_q;
		if (eff_l > 4'(LMAX)) eff_l = 4'(LMAX);
	end

	assign z_val  = 11'd1 << eff_l;
	assign zz_val = 21'd1 << {eff_l, 1'b0};
	assign nd     = {28'd0, direct_count_q};
	assign zmask  = 32'(z_val) - 32'd1;
	assign zc32   = {25'd0, zone_count_q};
	assign ind_en = (indirect_slot_q != 4'd0);
	assign dbl_en = (double_slot_q != 4'd0);

	// Load writes, taken at the accepting transfer
	assign load_val = short_entries_q ? {16'd0, req.value[15:0]} : req.value;
	assign map_wr   = cmd.accept && (req.cmd == CMD_MAP_LOAD)
		&& ({1'b0, req.map_slot} < 5'(MAP_SLOTS));
	assign store_wr = cmd.accept && (req.cmd == CMD_STORE_LOAD)
		&& (32'(req.store_block) < 32'(STORE_BLOCKS))
		&& (32'(req.store_entry) < 32'(MAX_ENTRIES));
	assign wr_lin   = 32'(req.store_block) * 32'(MAX_ENTRIES) + 32'(req.store_entry);

	always_ff @(posedge clk) begin
		if (map_wr) map_q[req.map_slot[SLOT_IW-1:0]] <= load_val;
	end

	// Capture the logical block of a translate
	always_ff @(posedge clk) begin
		if (cmd.accept && (req.cmd == CMD_TRANSLATE)) blk_q <= req.logical_block;
	end

	// Decode: find the region and offsets; bounds are compared in parallel
	assign lim_ind = nd + 32'(z_val);
	assign base2   = ind_en ? lim_ind : nd;
	assign lim_dbl = base2 + 32'(zz_val);
	assign b1      = blk_q - nd;
	assign b2      = blk_q - base2;

	always_comb begin
		region_d = REG_BEYOND;
		slot_d   = double_slot_q;
		ent_d    = IDX_W'(b2 >> eff_l);
		res_a_d  = lim_ind;
		if (blk_q < nd) begin
			region_d = REG_DIRECT;
			slot_d   = blk_q[3:0];
		end else if (ind_en && (blk_q < lim_ind)) begin
			region_d = REG_IND;
			slot_d   = indirect_slot_q;
			ent_d    = IDX_W'(b1);
		end else if (dbl_en && (blk_q < lim_dbl)) begin
			region_d = REG_DBL;
			res_a_d  = nd + 32'(zz_val) + 32'(z_val);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			region_q <= REG_BEYOND;
		end else if (cmd.decode) begin
			region_q <= region_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.decode) begin
			slot_q  <= slot_d;
			ent_q   <= ent_d;
			lo_q    <= IDX_W'(b2 & zmask);
			res_a_q <= res_a_d;
			res_b_q <= nd + (b2 & ~zmask) + {20'd0, z_val, 1'b0};
		end
	end

	// Read the map pointer; a slot past the map reads as zero
	assign ptr      = ({1'b0, slot_q} < 5'(MAP_SLOTS)) ? map_q[slot_q[SLOT_IW-1:0]] : 32'd0;
	assign ptr_zero = (ptr == 32'd0);
	assign ptr_ok   = (ptr < zc32);
	assign ptr_read = ((region_q == REG_IND) || (region_q == REG_DBL)) && !ptr_zero && ptr_ok;

	// Store read data; a block without storage reads as zero
	assign data    = rd_zero_q ? 32'd0
		: (short_entries_q ? {16'd0, rd_data_q[15:0]} : rd_data_q);
	assign l1_read = (region_q == REG_DBL) && (data != 32'd0) && (data < zc32);

	// Block store read request
	assign rd_req      = (cmd.pointer && ptr_read) || (cmd.level1 && l1_read);
	assign rd_blk      = cmd.pointer ? ptr : data;
	assign rd_ent      = cmd.pointer ? ent_q : lo_q;
	assign rd_in_range = (rd_blk < 32'(STORE_BLOCKS));
	assign rd_en       = rd_req && rd_in_range;
	assign rd_lin      = 32'(rd_blk[BLK_W-1:0]) * 32'(MAX_ENTRIES) + 32'(rd_ent);

	// Block store memory, registered read
	always_ff @(posedge clk) begin
		if (store_wr) store_mem[wr_lin[ADDR_W-1:0]] <= load_val;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_q <= store_mem[rd_lin[ADDR_W-1:0]];
		if (rd_req) rd_zero_q <= !rd_in_range;
	end

	// Form the result of the step that ends the walk
	always_comb begin
		res_load = 1'b0;
		res_d    = '0;
		if (cmd.pointer) begin
			case (region_q)
				REG_DIRECT: begin
					res_load = 1'b1;
					if (ptr_ok) begin
						res_d.status       = STAT_OK;
						res_d.mapped_value = ptr;
					end else begin
						res_d.status = STAT_DIRECT_RANGE;
					end
				end
				REG_IND: begin
					res_load           = !ptr_read;
					res_d.status       = ptr_zero ? STAT_IND_ZERO : STAT_IND_RANGE;
					res_d.mapped_value = res_a_q;
				end
				REG_DBL: begin
					res_load           = !ptr_read;
					res_d.status       = ptr_zero ? STAT_DBL_ZERO : STAT_DBL_RANGE;
					res_d.mapped_value = res_a_q;
				end
				REG_BEYOND: begin
					res_load     = 1'b1;
					res_d.status = triple_present_q ? STAT_TRIPLE : STAT_BEYOND;
				end
				default: ;
			endcase
		end else if (cmd.level1) begin
			if (region_q == REG_IND) begin
				res_load           = 1'b1;
				res_d.status       = (data >= zc32) ? STAT_IND_ENTRY : STAT_OK;
				res_d.mapped_value = data;
			end else begin
				res_load           = !l1_read;
				res_d.status       = (data == 32'd0) ? STAT_L1_ZERO : STAT_L1_RANGE;
				res_d.mapped_value = res_b_q;
			end
		end else if (cmd.level2) begin
			res_load = 1'b1;
			if (data >= zc32) begin
				res_d.status = STAT_DBL_ENTRY;
			end else begin
				res_d.status       = STAT_OK;
				res_d.mapped_value = data;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) res_q <= res_d;
	end

	// Output register: load on emit when free, drop on transfer
	assign out_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (cmd.emit && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && out_free) rsp_q <= res_q;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Status to the controller
	assign status.item_translate = (req.cmd == CMD_TRANSLATE);
	assign status.ptr_read       = ptr_read;
	assign status.l1_read        = l1_read;
	assign status.out_free       = out_free;

`ifndef ASSERT_OFF
	a_no_rd_wr_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		rd_req |-> !(map_wr || store_wr))
		else $error("store read issued during a load write");

	a_emit_loads_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && out_free |=> rsp_valid_q && (rsp_q == $past(res_q)))
		else $error("emit did not load the output register");

	a_level2_after_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.level2 |-> $past(cmd.level1) && $past(l1_read))
		else $error("second level step without a first level read");
`endif

endmodule

`default_nettype wire

>>> design/inode_block_map_translate_unit.sv
// Top level of the inode block map translator: controller and datapath.
// Depends on ibmt_pkg, ibmt_ctrl and ibmt_datapath.
//
//   channel  signals                           direction
//   req      req_valid, req_ready, req         in   (load or translate item)
//   rsp      rsp_valid, rsp_ready, rsp         out  (status, mapped value)
//   cfg      cfg_valid, cfg_ready, cfg_index,  in   (register write)
//            cfg_data
//
// Map and store loads are written at the accepting transfer. A translate runs
// the decode and pointer steps and then emit for a direct slot or an early
// status, adds the first level step through the single indirect level and the
// second through the double indirect level, one per dependent registered read.
// Reset clears the controller and output valid and loads register defaults;
// the inode map and block store are undefined until written, no clearing pass.
// A held result does not block loads; the next translate waits for emit.
`timescale 1ns / 1ps
`default_nettype none

module inode_block_map_translate_unit #(
	parameter int MAP_SLOTS    = 15,
	parameter int STORE_BLOCKS = 64,
	parameter int MAX_ENTRIES  = 512
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  ibmt_pkg::req_t  req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output ibmt_pkg::rsp_t  rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic [2:0]      cfg_index,
	input  logic [31:0]     cfg_data
);
	import ibmt_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t status;

	// Register writes are always taken
	assign cfg_ready = 1'b1;

	ibmt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ibmt_datapath #(
		.MAP_SLOTS    (MAP_SLOTS),
		.STORE_BLOCKS (STORE_BLOCKS),
		.MAX_ENTRIES  (MAX_ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
